[rtl/cpuld_pkg.sv]
// ----------------------------------------------------------------------------
// cpuld_pkg
// Shared widths, constants and control types of the cpu load averager.
// ----------------------------------------------------------------------------
package cpuld_pkg;

  // ring depth of the moving average
  localparam int WINDOW      = 5;

  // field widths
  localparam int COUNT_W     = 64;
  localparam int TICK_W      = 32;
  localparam int GAP_W       = 31;
  localparam int INTERVAL_W  = 16;
  localparam int LOAD_W      = 7;

  // derived widths
  localparam int FULL_LOAD_I = 100;
  localparam int PROD_W      = COUNT_W + LOAD_W;
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W       = $clog2(FULL_LOAD_I * WINDOW + 1);
  localparam int STEP_W      = $clog2(COUNT_W);

  // constants
  localparam logic [LOAD_W-1:0]     FULL_LOAD      = LOAD_W'(FULL_LOAD_I);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(200);

  // control of the bit-serial delta unit
  typedef struct packed {
    logic capture;   // load new counters for evaluation
    logic baseline;  // load new counters straight into the previous set
    logic shift;     // advance one bit
  } delta_ctl_t;

endpackage

[rtl/cpuld_in_if.sv]
// ----------------------------------------------------------------------------
// cpuld_in_if
// Sample channel: valid/ready handshake carrying tick and time counters.
// ----------------------------------------------------------------------------
interface cpuld_in_if;
  logic                            valid;
  logic                            ready;
  logic [cpuld_pkg::TICK_W-1:0]    now_ms;
  logic [cpuld_pkg::COUNT_W-1:0]   idle_count;
  logic [cpuld_pkg::COUNT_W-1:0]   kernel_count;
  logic [cpuld_pkg::COUNT_W-1:0]   user_count;

  modport source (output valid, output now_ms, output idle_count,
                  output kernel_count, output user_count, input ready);
  modport sink   (input valid, input now_ms, input idle_count,
                  input kernel_count, input user_count, output ready);
endinterface

[rtl/cpuld_out_if.sv]
// ----------------------------------------------------------------------------
// cpuld_out_if
// Result channel: valid/ready handshake carrying the averaged load.
// ----------------------------------------------------------------------------
interface cpuld_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpuld_pkg::LOAD_W-1:0]  load_percent;
  logic                          updated;

  modport source (output valid, output load_percent, output updated, input ready);
  modport sink   (input valid, input load_percent, input updated, output ready);
endinterface

[rtl/cpuld_delta.sv]
// ----------------------------------------------------------------------------
// cpuld_delta
// Bit-serial front end: forms the counter deltas, sys = d_user + d_kernel and
// num = sys - d_idle one bit per cycle while shift is set, lsb first, and rolls
// the new counters into the previous set as they are consumed.
// ----------------------------------------------------------------------------
module cpuld_delta (
  input  logic                           clk,
  input  cpuld_pkg::delta_ctl_t          ctl,
  input  logic [cpuld_pkg::COUNT_W-1:0]  idle_count,
  input  logic [cpuld_pkg::COUNT_W-1:0]  kernel_count,
  input  logic [cpuld_pkg::COUNT_W-1:0]  user_count,
  output logic [cpuld_pkg::COUNT_W-1:0]  sys_val,
  output logic [cpuld_pkg::COUNT_W-1:0]  num_val
);
  import cpuld_pkg::*;

  logic [COUNT_W-1:0] cur_idle, cur_kernel, cur_user;
  logic [COUNT_W-1:0] prev_idle, prev_kernel, prev_user;
  logic br_idle, br_kernel, br_user, cy_sys, br_num;
  logic br_idle_next, br_kernel_next, br_user_next, cy_sys_next, br_num_next;
  logic d_idle, d_kernel, d_user, s_bit, n_bit;

  // one bit of each subtract and add
  always_comb begin
    d_idle         = cur_idle[0] ^ prev_idle[0] ^ br_idle;
    br_idle_next   = (~cur_idle[0] & prev_idle[0]) |
                     (~(cur_idle[0] ^ prev_idle[0]) & br_idle);
    d_kernel       = cur_kernel[0] ^ prev_kernel[0] ^ br_kernel;
    br_kernel_next = (~cur_kernel[0] & prev_kernel[0]) |
                     (~(cur_kernel[0] ^ prev_kernel[0]) & br_kernel);
    d_user         = cur_user[0] ^ prev_user[0] ^ br_user;
    br_user_next   = (~cur_user[0] & prev_user[0]) |
                     (~(cur_user[0] ^ prev_user[0]) & br_user);
    s_bit          = d_kernel ^ d_user ^ cy_sys;
    cy_sys_next    = (d_kernel & d_user) | (d_kernel & cy_sys) | (d_user & cy_sys);
    n_bit          = s_bit ^ d_idle ^ br_num;
    br_num_next    = (~s_bit & d_idle) | (~(s_bit ^ d_idle) & br_num);
  end

  // shift registers and carry chain state
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur_idle   <= idle_count;
      cur_kernel <= kernel_count;
      cur_user   <= user_count;
      br_idle    <= 1'b0;
      br_kernel  <= 1'b0;
      br_user    <= 1'b0;
      cy_sys     <= 1'b0;
      br_num     <= 1'b0;
    end
    if (ctl.baseline) begin
      prev_idle   <= idle_count;
      prev_kernel <= kernel_count;
      prev_user   <= user_count;
    end
    if (ctl.shift) begin
      cur_idle    <= {1'b0, cur_idle[COUNT_W-1:1]};
      cur_kernel  <= {1'b0, cur_kernel[COUNT_W-1:1]};
      cur_user    <= {1'b0, cur_user[COUNT_W-1:1]};
      prev_idle   <= {cur_idle[0], prev_idle[COUNT_W-1:1]};
      prev_kernel <= {cur_kernel[0], prev_kernel[COUNT_W-1:1]};
      prev_user   <= {cur_user[0], prev_user[COUNT_W-1:1]};
      sys_val     <= {s_bit, sys_val[COUNT_W-1:1]};
      num_val     <= {n_bit, num_val[COUNT_W-1:1]};
      br_idle     <= br_idle_next;
      br_kernel   <= br_kernel_next;
      br_user     <= br_user_next;
      cy_sys      <= cy_sys_next;
      br_num      <= br_num_next;
    end
  end

endmodule

[rtl/cpu_load_percent_averager.sv]
// ----------------------------------------------------------------------------
// cpu_load_percent_averager
// Turns samples of cumulative idle/kernel/user counters into a processor load
// in percent, averaged over the last few evaluated intervals.
// ----------------------------------------------------------------------------
//  channel     dir  handshake          payload
//  sample_ch   in   valid/ready        now_ms, idle_count, kernel_count, user_count
//  result_ch   out  valid/ready        load_percent, updated
//  cfg_wr_*    in   write enable       min_interval_ms
//
//  one sample at a time; early and baseline samples go from idle straight to done
//  evaluated samples run the bit-serial delta pass, the magnitude, compare and
//  multiply steps, the 7-step quotient loop, the ring write, the sum and the
//  mean loop (multiply and quotient loop skipped when the load is zero or full)
//  rst is synchronous; no clearing pass, the ring is read only where filled
//  the result register holds while result_ch stalls; the next sample is
//  taken meanwhile and waits in the done state if the register is still full
// ----------------------------------------------------------------------------
module cpu_load_percent_averager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cpuld_pkg::INTERVAL_W-1:0]  cfg_wr_data,
  cpuld_in_if.sink                          sample_ch,
  cpuld_out_if.source                       result_ch
);
  import cpuld_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SERIAL = 10'b0000000010,
    S_MAG    = 10'b0000000100,
    S_CMP    = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_DIV    = 10'b0000100000,
    S_RING   = 10'b0001000000,
    S_SUM    = 10'b0010000000,
    S_MEAN   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t                 state;
  logic [STEP_W-1:0]      step;
  logic [INTERVAL_W-1:0]  min_interval;
  logic                   primed;
  logic [TICK_W-1:0]      tick_mark;
  logic [POS_W-1:0]       ring_pos;
  logic [FILL_W-1:0]      ring_fill;
  logic [LOAD_W-1:0]      last_load;
  logic [LOAD_W-1:0]      load_ring [WINDOW];
  logic                   zero_load;
  logic [COUNT_W-1:0]     ms, mn;
  logic [PROD_W-1:0]      prod;
  logic [COUNT_W-1:0]     rem;
  logic [LOAD_W-1:0]      quo;
  logic [SUM_W-1:0]       sum_sr;
  logic [FILL_W-1:0]      mrem;
  logic [LOAD_W-1:0]      res_load;
  logic                   res_upd;
  logic                   out_valid;
  logic [LOAD_W-1:0]      out_load;
  logic                   out_upd;

  logic                   take;
  logic [TICK_W-1:0]      tick_gap;
  logic                   too_early;
  delta_ctl_t             dctl;
  logic [COUNT_W-1:0]     sys_val, num_val;
  logic [PROD_W-1:0]      prod_full;
  logic [COUNT_W:0]       r2, r2_diff;
  logic                   q_bit;
  logic [SUM_W-1:0]       ring_total;
  logic [FILL_W:0]        m2, m2_diff;
  logic                   m_bit;
  logic [SUM_W-1:0]       mean_q;

  // handshake and interval check
  assign sample_ch.ready = (state == S_IDLE);
  assign take            = sample_ch.valid & sample_ch.ready;
  assign tick_gap        = sample_ch.now_ms - tick_mark;
  assign too_early       = tick_gap[GAP_W-1:0] <= GAP_W'(min_interval);

  assign result_ch.valid        = out_valid;
  assign result_ch.load_percent = out_load;
  assign result_ch.updated      = out_upd;

  // serial delta unit control
  always_comb begin
    dctl.capture  = take & ~too_early & primed;
    dctl.baseline = take & ~too_early & ~primed;
    dctl.shift    = (state == S_SERIAL);
  end

  cpuld_delta u_delta (
    .clk          (clk),
    .ctl          (dctl),
    .idle_count   (sample_ch.idle_count),
    .kernel_count (sample_ch.kernel_count),
    .user_count   (sample_ch.user_count),
    .sys_val      (sys_val),
    .num_val      (num_val)
  );

  // product finish, quotient step and mean step
  always_comb begin
    prod_full = prod + (PROD_W'(mn) << 2);
    r2        = {rem, quo[LOAD_W-1]};
    r2_diff   = r2 - {1'b0, ms};
    q_bit     = (r2 >= {1'b0, ms});
    m2        = {mrem, sum_sr[SUM_W-1]};
    m2_diff   = m2 - {1'b0, ring_fill};
    m_bit     = (m2 >= {1'b0, ring_fill});
    mean_q    = {sum_sr[SUM_W-2:0], m_bit};
  end

  // sum of the filled ring entries
  always_comb begin
    ring_total = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (FILL_W'(i) < ring_fill) begin
        ring_total = ring_total + SUM_W'(load_ring[i]);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      min_interval <= INTERVAL_RESET;
      primed       <= 1'b0;
      tick_mark    <= '0;
      ring_pos     <= '0;
      ring_fill    <= '0;
      last_load    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_interval <= cfg_wr_data;
      end
      // result register: load from done, drop once taken
      if (state == S_DONE && (!out_valid || result_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (too_early) begin
              res_load <= last_load;
              res_upd  <= 1'b0;
              state    <= S_DONE;
            end else if (!primed) begin
              primed    <= 1'b1;
              tick_mark <= sample_ch.now_ms;
              last_load <= '0;
              res_load  <= '0;
              res_upd   <= 1'b1;
              state     <= S_DONE;
            end else begin
              tick_mark <= sample_ch.now_ms;
              step      <= '0;
              state     <= S_SERIAL;
            end
          end
        end
        S_SERIAL: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(COUNT_W - 1)) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          zero_load <= (sys_val == '0) | (sys_val[COUNT_W-1] != num_val[COUNT_W-1]);
          ms        <= sys_val[COUNT_W-1] ? (~sys_val + COUNT_W'(1)) : sys_val;
          mn        <= num_val[COUNT_W-1] ? (~num_val + COUNT_W'(1)) : num_val;
          state     <= S_CMP;
        end
        S_CMP: begin
          if (zero_load) begin
            quo   <= '0;
            state <= S_RING;
          end else if (mn >= ms) begin
            quo   <= FULL_LOAD;
            state <= S_RING;
          end else begin
            prod  <= (PROD_W'(mn) << 6) + (PROD_W'(mn) << 5);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rem   <= prod_full[PROD_W-1:LOAD_W];
          quo   <= prod_full[LOAD_W-1:0];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= q_bit ? r2_diff[COUNT_W-1:0] : r2[COUNT_W-1:0];
          quo  <= {quo[LOAD_W-2:0], q_bit};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(LOAD_W - 1)) begin
            state <= S_RING;
          end
        end
        S_RING: begin
          load_ring[ring_pos] <= quo;
          ring_pos <= (ring_pos == POS_W'(WINDOW - 1)) ? '0 : ring_pos + POS_W'(1);
          if (ring_fill < FILL_W'(WINDOW)) begin
            ring_fill <= ring_fill + FILL_W'(1);
          end
          state <= S_SUM;
        end
        S_SUM: begin
          sum_sr <= ring_total;
          mrem   <= '0;
          step   <= '0;
          state  <= S_MEAN;
        end
        S_MEAN: begin
          mrem   <= m_bit ? m2_diff[FILL_W-1:0] : m2[FILL_W-1:0];
          sum_sr <= mean_q;
          step   <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            last_load <= mean_q[LOAD_W-1:0];
            res_load  <= mean_q[LOAD_W-1:0];
            res_upd   <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result_ch.ready) begin
            out_load  <= res_load;
            out_upd   <= res_upd;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(WINDOW))
    else $error("ring fill beyond window");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ring_pos < POS_W'(WINDOW))
    else $error("ring position beyond window");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < ms))
    else $error("quotient remainder not below divisor");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    last_load <= FULL_LOAD)
    else $error("load above full scale");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> (state != S_IDLE))
    else $error("sample accepted without leaving idle");

endmodule
